>>> hdl/hkrb_pkg.sv
// Shared types, command codes and the AZERTY key map for the HID keyboard
// report builder. No dependencies.
`timescale 1ns / 1ps

package hkrb_pkg;

    localparam int SLOT_COUNT_DEFAULT = 6;
    localparam int REPORT_SLOTS       = 6;

    localparam logic [1:0] CMD_PRESS       = 2'd0;
    localparam logic [1:0] CMD_RELEASE     = 2'd1;
    localparam logic [1:0] CMD_RELEASE_ALL = 2'd2;
    localparam logic [1:0] CMD_WRITE       = 2'd3;

    localparam logic [7:0] KEY_RAW_BASE  = 8'd136;
    localparam logic [7:0] MAP_SH        = 8'h80;
    localparam logic [7:0] MAP_AG        = 8'hC0;
    localparam logic [7:0] MOD_SHIFT     = 8'h02;
    localparam logic [7:0] MOD_ALTGR     = 8'h40;
    localparam logic [7:0] CODE_AG_MASK  = 8'h3F;
    localparam logic [7:0] CODE_SH_MASK  = 8'h7F;
    localparam logic [7:0] ISO_STAND_IN  = 8'h32;
    localparam logic [7:0] ISO_USAGE     = 8'h64;

    localparam logic [7:0] AZERTY_MAP [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2c, 8'h38, 8'h20, 8'h20 | MAP_AG, 8'h30, 8'h34 | MAP_SH, 8'h1e, 8'h21,
        8'h22, 8'h2d, 8'h31, 8'h2e | MAP_SH, 8'h10, 8'h23, 8'h36 | MAP_SH, 8'h37 | MAP_SH,
        8'h27 | MAP_SH, 8'h1e | MAP_SH, 8'h1f | MAP_SH, 8'h20 | MAP_SH,
        8'h21 | MAP_SH, 8'h22 | MAP_SH, 8'h23 | MAP_SH, 8'h24 | MAP_SH,
        8'h25 | MAP_SH, 8'h26 | MAP_SH, 8'h37, 8'h36, 8'h32, 8'h2e, 8'h32 | MAP_SH,
        8'h10 | MAP_SH,
        8'h27 | MAP_AG, 8'h14 | MAP_SH, 8'h05 | MAP_SH, 8'h06 | MAP_SH,
        8'h07 | MAP_SH, 8'h08 | MAP_SH, 8'h09 | MAP_SH, 8'h0a | MAP_SH,
        8'h0b | MAP_SH, 8'h0c | MAP_SH, 8'h0d | MAP_SH, 8'h0e | MAP_SH,
        8'h0f | MAP_SH, 8'h33 | MAP_SH, 8'h11 | MAP_SH, 8'h12 | MAP_SH,
        8'h13 | MAP_SH, 8'h04 | MAP_SH, 8'h15 | MAP_SH, 8'h16 | MAP_SH,
        8'h17 | MAP_SH, 8'h18 | MAP_SH, 8'h19 | MAP_SH, 8'h1d | MAP_SH,
        8'h1b | MAP_SH, 8'h1c | MAP_SH, 8'h1a | MAP_SH, 8'h22 | MAP_AG,
        8'h25 | MAP_AG, 8'h2d | MAP_AG, 8'h26 | MAP_AG, 8'h25,
        8'h24 | MAP_AG, 8'h14, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
        8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h33, 8'h11, 8'h12,
        8'h13, 8'h04, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1d,
        8'h1b, 8'h1c, 8'h1a, 8'h21 | MAP_AG, 8'h23 | MAP_AG, 8'h2e | MAP_AG,
        8'h1f | MAP_AG, 8'h00
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT,
        ST_REL
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PRESS,
        OP_RELEASE,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic       load;
        op_t        op;
        logic       keep_ok;
        logic       last;
    } dp_ctrl_t;

    typedef struct packed {
        logic [1:0] command;
        logic       last;
    } dp_stat_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] usage;
        logic [7:0] mask;
    } xlat_t;

    function automatic xlat_t translate_key(input logic [7:0] key);
        xlat_t      r;
        logic [7:0] code;
        logic [7:0] base;
        r.valid = 1'b1;
        r.usage = 8'h00;
        r.mask  = 8'h00;
        code    = AZERTY_MAP[key[6:0]];
        base    = code;
        if (key >= KEY_RAW_BASE)
        begin
            r.usage = key - KEY_RAW_BASE;
        end
        else if (key[7])
        begin
            r.mask = 8'h01 << key[2:0];
        end
        else if (code == 8'h00)
        begin
            r.valid = 1'b0;
        end
        else
        begin
            if ((code & MAP_AG) == MAP_AG)
            begin
                r.mask = MOD_ALTGR;
                base   = code & CODE_AG_MASK;
            end
            else if ((code & MAP_SH) == MAP_SH)
            begin
                r.mask = MOD_SHIFT;
                base   = code & CODE_SH_MASK;
            end
            r.usage = (base == ISO_STAND_IN) ? ISO_USAGE : base;
        end
        return r;
    endfunction

endpackage

>>> hdl/hkrb_datapath.sv
// Report state, key translation register and result flags.
// Depends on hkrb_pkg; driven by hkrb_controller commands.
`timescale 1ns / 1ps

module hkrb_datapath #(
    parameter int SLOT_COUNT = hkrb_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hkrb_pkg::dp_ctrl_t  ctrl,
    output hkrb_pkg::dp_stat_t  stat,
    input  logic [1:0]          command,
    input  logic [7:0]          key,
    output logic                ok,
    output logic                sent,
    output logic                last,
    output logic [7:0]          modifier_bits,
    output logic [7:0]          report_slots [hkrb_pkg::REPORT_SLOTS]
);

    logic [1:0]      command_reg;
    hkrb_pkg::xlat_t xlat_reg;
    logic [7:0]      mods_reg;
    logic [7:0]      slots_reg [SLOT_COUNT];
    logic            ok_reg;
    logic            sent_reg;
    logic            last_reg;

    logic [SLOT_COUNT-1:0] hit;
    logic [SLOT_COUNT-1:0] free_sel;
    logic                  taken;

    always_comb
    begin
        taken = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            hit[i]      = (slots_reg[i] == xlat_reg.usage);
            free_sel[i] = (slots_reg[i] == 8'h00) && !taken;
            taken       = taken | (slots_reg[i] == 8'h00);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mods_reg <= 8'h00;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slots_reg[i] <= 8'h00;
            end
            ok_reg   <= 1'b0;
            sent_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            case (ctrl.op)
                hkrb_pkg::OP_PRESS:
                begin
                    last_reg <= ctrl.last;
                    if (!xlat_reg.valid)
                    begin
                        ok_reg   <= 1'b0;
                        sent_reg <= 1'b0;
                    end
                    else
                    begin
                        mods_reg <= mods_reg | xlat_reg.mask;
                        ok_reg   <= (|hit) || taken;
                        sent_reg <= (|hit) || taken;
                        if (!(|hit))
                        begin
                            for (int i = 0; i < SLOT_COUNT; i++)
                            begin
                                if (free_sel[i])
                                begin
                                    slots_reg[i] <= xlat_reg.usage;
                                end
                            end
                        end
                    end
                end
                hkrb_pkg::OP_RELEASE:
                begin
                    last_reg <= ctrl.last;
                    sent_reg <= xlat_reg.valid;
                    if (!ctrl.keep_ok)
                    begin
                        ok_reg <= xlat_reg.valid;
                    end
                    if (xlat_reg.valid)
                    begin
                        mods_reg <= mods_reg & ~xlat_reg.mask;
                        if (xlat_reg.usage != 8'h00)
                        begin
                            for (int i = 0; i < SLOT_COUNT; i++)
                            begin
                                if (hit[i])
                                begin
                                    slots_reg[i] <= 8'h00;
                                end
                            end
                        end
                    end
                end
                hkrb_pkg::OP_CLEAR:
                begin
                    last_reg <= ctrl.last;
                    ok_reg   <= 1'b1;
                    sent_reg <= 1'b1;
                    mods_reg <= 8'h00;
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        slots_reg[i] <= 8'h00;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            command_reg <= command;
            xlat_reg    <= hkrb_pkg::translate_key(key);
        end
    end

    assign stat.command  = command_reg;
    assign stat.last     = last_reg;
    assign ok            = ok_reg;
    assign sent          = sent_reg;
    assign last          = last_reg;
    assign modifier_bits = mods_reg;

    for (genvar j = 0; j < hkrb_pkg::REPORT_SLOTS; j++)
    begin : g_report
        if (j < SLOT_COUNT)
        begin : g_kept
            assign report_slots[j] = slots_reg[j];
        end
        else
        begin : g_absent
            assign report_slots[j] = 8'h00;
        end
    end

endmodule

>>> hdl/hkrb_controller.sv
// Request sequencer: accept, execute, present, and the release phase of write.
// Depends on hkrb_pkg; drives hkrb_datapath.
`timescale 1ns / 1ps

module hkrb_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  hkrb_pkg::dp_stat_t  stat,
    output hkrb_pkg::dp_ctrl_t  ctrl
);

    hkrb_pkg::state_t state_reg;
    hkrb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hkrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        ctrl.load    = 1'b0;
        ctrl.op      = hkrb_pkg::OP_NONE;
        ctrl.keep_ok = 1'b0;
        ctrl.last    = 1'b1;
        case (state_reg)
            hkrb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = hkrb_pkg::ST_EXEC;
                end
            end
            hkrb_pkg::ST_EXEC:
            begin
                case (stat.command)
                    hkrb_pkg::CMD_PRESS:       ctrl.op = hkrb_pkg::OP_PRESS;
                    hkrb_pkg::CMD_RELEASE:     ctrl.op = hkrb_pkg::OP_RELEASE;
                    hkrb_pkg::CMD_RELEASE_ALL: ctrl.op = hkrb_pkg::OP_CLEAR;
                    default:
                    begin
                        ctrl.op   = hkrb_pkg::OP_PRESS;
                        ctrl.last = 1'b0;
                    end
                endcase
                state_next = hkrb_pkg::ST_OUT;
            end
            hkrb_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = stat.last ? hkrb_pkg::ST_IDLE : hkrb_pkg::ST_REL;
                end
            end
            hkrb_pkg::ST_REL:
            begin
                ctrl.op      = hkrb_pkg::OP_RELEASE;
                ctrl.keep_ok = 1'b1;
                state_next   = hkrb_pkg::ST_OUT;
            end
            default:
            begin
                state_next = hkrb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/hid_keyboard_report_builder.sv
// Top level of the HID boot keyboard report builder (six reported slots).
// Depends on hkrb_pkg, hkrb_controller and hkrb_datapath.
//
// One request at a time. A press, release or release-all request passes
// from acceptance to its result through accept, execute and present; a write
// request returns two results, the press and then the release. Report fields
// always show the state after the step, and sent tells whether that report
// goes to the host. Slots beyond six are kept but not shown on the ports;
// with fewer than six slots the missing fields read 0.
`timescale 1ns / 1ps

module hid_keyboard_report_builder #(
    parameter int SLOT_COUNT = hkrb_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] key,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       ok,
    output logic       sent,
    output logic [7:0] modifier_bits,
    output logic [7:0] slot0,
    output logic [7:0] slot1,
    output logic [7:0] slot2,
    output logic [7:0] slot3,
    output logic [7:0] slot4,
    output logic [7:0] slot5,
    output logic       last
);

    hkrb_pkg::dp_ctrl_t ctrl;
    hkrb_pkg::dp_stat_t stat;
    logic [7:0]         report_slots [hkrb_pkg::REPORT_SLOTS];

    hkrb_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    hkrb_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .command       (command),
        .key           (key),
        .ok            (ok),
        .sent          (sent),
        .last          (last),
        .modifier_bits (modifier_bits),
        .report_slots  (report_slots)
    );

    assign slot0 = report_slots[0];
    assign slot1 = report_slots[1];
    assign slot2 = report_slots[2];
    assign slot3 = report_slots[3];
    assign slot4 = report_slots[4];
    assign slot5 = report_slots[5];

endmodule
